// ===== rtl/gbsp_pkg.sv =====
// shared types, byte codes and small tables of the gif block structure parser
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gbsp_pkg;

   localparam int CSR_INDEX_W = 8;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_WIDTH  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_HEIGHT = 8'd1;

   localparam logic [15:0] MAX_WIDTH_RESET  = 16'd480;
   localparam logic [15:0] MAX_HEIGHT_RESET = 16'd320;

   // block introducers and labels
   localparam logic [7:0] BYTE_IMAGE_SEP   = 8'h2C;
   localparam logic [7:0] BYTE_EXT_INTRO   = 8'h21;
   localparam logic [7:0] BYTE_GCE_LABEL   = 8'hF9;
   localparam logic [7:0] BYTE_TRAILER     = 8'h3B;
   localparam logic [7:0] BYTE_SIG_VER_87  = 8'h37;
   localparam logic [7:0] FLAG_TABLE_FOLLOWS = 8'h80;
   localparam logic [7:0] FLAG_TABLE_SIZE    = 8'h07;

   localparam logic [15:0] DELAY_MIN_TICKS = 16'd2;

   // error codes carried in payload_byte
   localparam logic [7:0] ERR_SIGNATURE = 8'd0;
   localparam logic [7:0] ERR_TOO_WIDE  = 8'd1;
   localparam logic [7:0] ERR_EARLY_END = 8'd2;

   typedef enum logic [3:0] {
      PH_HDR,
      PH_GCT,
      PH_BLOCK,
      PH_EXT_LABEL,
      PH_GCE_SIZE,
      PH_GCE_DATA,
      PH_EXT_SIZE,
      PH_EXT_DATA,
      PH_DESC,
      PH_LCT,
      PH_LZW,
      PH_IMG_SIZE,
      PH_IMG_DATA,
      PH_IDLE
   } phase_type;

   typedef enum logic [2:0] {
      KIND_CANVAS = 3'd0,
      KIND_FRAME  = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_END    = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   // fields of the last graphics control block
   typedef struct packed {
      logic        present;
      logic [2:0]  disposal;
      logic        tflag;
      logic [7:0]  tidx;
      logic [15:0] delay;
   } gce_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] coord_x;
      logic [15:0] coord_y;
      logic [15:0] extent_w;
      logic [15:0] extent_h;
      logic [7:0]  packed_flags;
      logic [2:0]  disposal;
      logic        has_transparent;
      logic [7:0]  palette_index;
      logic [31:0] delay_ms;
      logic [7:0]  payload_byte;
      logic [15:0] frame_count;
   } result_type;

   // colour table length in bytes: 3 << (size + 1)
   function automatic logic [9:0] table_bytes(input logic [7:0] flags);
      logic [2:0] sz;
      sz = flags[2:0] & FLAG_TABLE_SIZE[2:0];
      return 10'(10'd6 << sz);
   endfunction

   // signature text "GIF89a"
   function automatic logic [7:0] sig_char(input logic [2:0] n);
      logic [7:0] c;
      unique case (n)
         3'd0: c = 8'h47;
         3'd1: c = 8'h49;
         3'd2: c = 8'h46;
         3'd3: c = 8'h38;
         3'd4: c = 8'h39;
         3'd5: c = 8'h61;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/gbsp_channels.sv =====
// valid/ready channel interfaces of the gif block structure parser
// depends on gbsp_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gbsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       final_byte;

   modport source (output valid, output file_byte, output final_byte, input ready);
   modport sink   (input valid, input file_byte, input final_byte, output ready);
endinterface

interface gbsp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [15:0] coord_x;
   logic [15:0] coord_y;
   logic [15:0] extent_w;
   logic [15:0] extent_h;
   logic [7:0]  packed_flags;
   logic [2:0]  disposal;
   logic        has_transparent;
   logic [7:0]  palette_index;
   logic [31:0] delay_ms;
   logic [7:0]  payload_byte;
   logic [15:0] frame_count;

   modport source (output valid, output kind, output coord_x, output coord_y,
                   output extent_w, output extent_h, output packed_flags,
                   output disposal, output has_transparent, output palette_index,
                   output delay_ms, output payload_byte, output frame_count,
                   input ready);
   modport sink   (input valid, input kind, input coord_x, input coord_y,
                   input extent_w, input extent_h, input packed_flags,
                   input disposal, input has_transparent, input palette_index,
                   input delay_ms, input payload_byte, input frame_count,
                   output ready);
endinterface

interface gbsp_csr_if;
   logic                             valid;
   logic                             ready;
   logic [gbsp_pkg::CSR_INDEX_W-1:0] reg_index;
   logic [15:0]                      data;

   modport source (output valid, output reg_index, output data, input ready);
   modport sink   (input valid, input reg_index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/gbsp_delay_calc.sv =====
// frame delay in ms from the control block and the saturating running duration
// depends on gbsp_pkg
`timescale 1ns / 1ps
`default_nettype none

module gbsp_delay_calc (
   input  var gbsp_pkg::gce_type gce,
   input  wire logic [31:0]      total,
   output logic      [31:0]      delay_ms,
   output logic      [31:0]      total_next
);
   import gbsp_pkg::*;

   logic [15:0] ticks;
   logic [19:0] ms;
   logic [32:0] sum;

   always_comb begin
      ticks = (gce.delay < DELAY_MIN_TICKS) ? DELAY_MIN_TICKS : gce.delay;
      // times ten as 8x + 2x
      ms = {1'b0, ticks, 3'b000} + {3'b000, ticks, 1'b0};
      delay_ms = gce.present ? {12'h000, ms} : 32'h0000_0000;
      sum = {1'b0, total} + {1'b0, delay_ms};
      total_next = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   end

endmodule

`default_nettype wire

// ===== rtl/gif_block_structure_parser_core.sv =====
// top level of the gif block structure parser: byte walker and result register
// depends on gbsp_pkg, gbsp_channels and gbsp_delay_calc
`timescale 1ns / 1ps
`default_nettype none

// GIF87a/GIF89a block structure parser. One file byte is taken per transfer on
// req_chan and the block sustains one byte per clock cycle: each byte updates
// the parse state in the same cycle and any result it causes (canvas info,
// frame record, image data byte, end or error) lands in a single result
// register on rsp_chan. A new byte is taken while that register is empty or is
// being emptied in the same cycle, so bytes flow with no stall as long as the
// sink takes results when they are offered. The longest path runs from the
// byte handshake through the next-state logic and the 32-bit saturating
// duration add into the state and result registers.
// Colour tables are counted out and skipped, control blocks are decoded and
// apply to the next frame only. After an end or error the parser drops bytes
// until one marked final; the byte after a final byte starts a new file.
// max_canvas_width (index 0) and max_canvas_height (index 1) are written on
// csr_chan, which is always ready; other indexes are ignored.
module gif_block_structure_parser_core (
   input  wire logic  clock,
   input  wire logic  reset,
   gbsp_req_if.sink   req_chan,
   gbsp_rsp_if.source rsp_chan,
   gbsp_csr_if.sink   csr_chan
);
   import gbsp_pkg::*;

   // configuration
   logic [15:0] max_w_ff, max_h_ff;

   // parse state
   phase_type   phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] canvas_w_ff, canvas_w_in;
   logic [15:0] canvas_h_ff, canvas_h_in;
   logic [7:0]  screen_flags_ff, screen_flags_in;
   logic [7:0]  background_ff, background_in;
   logic [15:0] geom_ff [4];
   logic [15:0] geom_in [4];
   logic [7:0]  image_flags_ff, image_flags_in;
   gce_type     gce_ff, gce_in;
   logic [15:0] frames_ff, frames_in;
   logic [31:0] total_ff, total_in;
   logic        sig_ok_ff, sig_ok_in;

   // result register
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   result_type  res;
   logic        res_valid;
   logic        accept;
   logic        closed;
   logic [7:0]  b;
   logic [31:0] frame_delay;
   logic [31:0] total_after;

   assign b      = req_chan.file_byte;
   // skid-free: take a byte when the result slot is free or draining now
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   gbsp_delay_calc u_delay (
      .gce        (gce_ff),
      .total      (total_ff),
      .delay_ms   (frame_delay),
      .total_next (total_after)
   );

   // next state and result of the byte being transferred
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      left_in         = left_ff;
      canvas_w_in     = canvas_w_ff;
      canvas_h_in     = canvas_h_ff;
      screen_flags_in = screen_flags_ff;
      background_in   = background_ff;
      geom_in         = geom_ff;
      image_flags_in  = image_flags_ff;
      gce_in          = gce_ff;
      frames_in       = frames_ff;
      total_in        = total_ff;
      sig_ok_in       = sig_ok_ff;
      res             = '0;
      res_valid       = 1'b0;
      closed          = 1'b0;

      if (accept) begin
         unique case (phase_ff)
            PH_HDR: begin
               if (count_ff < 10'd6) begin
                  if (!((b == sig_char(count_ff[2:0])) ||
                        (count_ff == 10'd4 && b == BYTE_SIG_VER_87))) begin
                     sig_ok_in = 1'b0;
                  end
                  if (count_ff == 10'd5 && !sig_ok_in) begin
                     res_valid = 1'b1;
                     res.kind = KIND_ERROR;
                     res.payload_byte = ERR_SIGNATURE;
                     phase_in = PH_IDLE;
                  end else begin
                     count_in = count_ff + 10'd1;
                  end
               end else if (count_ff < 10'd12) begin
                  unique case (count_ff[3:0])
                     4'd6:    canvas_w_in = {8'h00, b};
                     4'd7:    canvas_w_in = {b, canvas_w_ff[7:0]};
                     4'd8:    canvas_h_in = {8'h00, b};
                     4'd9:    canvas_h_in = {b, canvas_h_ff[7:0]};
                     4'd10:   screen_flags_in = b;
                     default: background_in = b;
                  endcase
                  count_in = count_ff + 10'd1;
               end else if (canvas_w_ff > max_w_ff || canvas_h_ff > max_h_ff) begin
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.payload_byte = ERR_TOO_WIDE;
                  phase_in = PH_IDLE;
               end else begin
                  res_valid = 1'b1;
                  res.kind = KIND_CANVAS;
                  res.extent_w = canvas_w_ff;
                  res.extent_h = canvas_h_ff;
                  res.packed_flags = screen_flags_ff;
                  res.palette_index = background_ff;
                  if ((screen_flags_ff & FLAG_TABLE_FOLLOWS) != 8'h00) begin
                     count_in = table_bytes(screen_flags_ff);
                     phase_in = PH_GCT;
                  end else begin
                     phase_in = PH_BLOCK;
                  end
               end
            end
            PH_GCT, PH_LCT: begin
               if (count_ff != 10'd0) begin
                  count_in = count_ff - 10'd1;
               end
               if (count_in == 10'd0) begin
                  phase_in = (phase_ff == PH_GCT) ? PH_BLOCK : PH_LZW;
               end
            end
            PH_BLOCK: begin
               priority if (b == BYTE_IMAGE_SEP) begin
                  count_in = 10'd0;
                  phase_in = PH_DESC;
               end else if (b == BYTE_EXT_INTRO) begin
                  phase_in = PH_EXT_LABEL;
               end else if (b == BYTE_TRAILER) begin
                  res_valid = 1'b1;
                  res.kind = KIND_END;
                  res.delay_ms = total_ff;
                  phase_in = PH_IDLE;
               end else begin
                  // unknown introducer: skipped
                  phase_in = PH_BLOCK;
               end
            end
            PH_EXT_LABEL: begin
               if (b == BYTE_GCE_LABEL) begin
                  gce_in = '0;
                  gce_in.present = 1'b1;
                  phase_in = PH_GCE_SIZE;
               end else begin
                  phase_in = PH_EXT_SIZE;
               end
            end
            PH_GCE_SIZE: begin
               if (b == 8'h00) begin
                  phase_in = PH_BLOCK;
               end else begin
                  left_in = b;
                  count_in = 10'd0;
                  phase_in = PH_GCE_DATA;
               end
            end
            PH_GCE_DATA: begin
               unique case (count_ff)
                  10'd0: begin
                     gce_in.disposal = b[4:2];
                     gce_in.tflag = b[0];
                  end
                  10'd1:   gce_in.delay = {gce_ff.delay[15:8], b};
                  10'd2:   gce_in.delay = {b, gce_ff.delay[7:0]};
                  10'd3:   gce_in.tidx = b;
                  default: gce_in = gce_ff;
               endcase
               if (count_ff < 10'd4) begin
                  count_in = count_ff + 10'd1;
               end
               left_in = left_ff - 8'd1;
               if (left_in == 8'd0) begin
                  phase_in = PH_EXT_SIZE;
               end
            end
            PH_EXT_SIZE, PH_IMG_SIZE: begin
               if (b == 8'h00) begin
                  phase_in = PH_BLOCK;
               end else begin
                  left_in = b;
                  phase_in = (phase_ff == PH_EXT_SIZE) ? PH_EXT_DATA : PH_IMG_DATA;
               end
            end
            PH_EXT_DATA, PH_IMG_DATA: begin
               if (phase_ff == PH_IMG_DATA) begin
                  res_valid = 1'b1;
                  res.kind = KIND_DATA;
                  res.payload_byte = b;
               end
               left_in = left_ff - 8'd1;
               if (left_in == 8'd0) begin
                  phase_in = (phase_ff == PH_EXT_DATA) ? PH_EXT_SIZE : PH_IMG_SIZE;
               end
            end
            PH_DESC: begin
               if (count_ff < 10'd8) begin
                  if (count_ff[0]) begin
                     geom_in[count_ff[2:1]] = {b, geom_ff[count_ff[2:1]][7:0]};
                  end else begin
                     geom_in[count_ff[2:1]] = {8'h00, b};
                  end
                  count_in = count_ff + 10'd1;
               end else begin
                  image_flags_in = b;
                  if ((b & FLAG_TABLE_FOLLOWS) != 8'h00) begin
                     count_in = table_bytes(b);
                     phase_in = PH_LCT;
                  end else begin
                     phase_in = PH_LZW;
                  end
               end
            end
            PH_LZW: begin
               // frame record; the code size byte rides in payload_byte
               if (frames_ff != 16'hFFFF) begin
                  frames_in = frames_ff + 16'd1;
               end
               res_valid = 1'b1;
               res.kind = KIND_FRAME;
               res.coord_x = geom_ff[0];
               res.coord_y = geom_ff[1];
               res.extent_w = geom_ff[2];
               res.extent_h = geom_ff[3];
               res.packed_flags = image_flags_ff;
               if (gce_ff.present) begin
                  res.disposal = gce_ff.disposal;
                  res.has_transparent = gce_ff.tflag;
                  res.palette_index = gce_ff.tidx;
               end
               res.delay_ms = frame_delay;
               res.payload_byte = b;
               total_in = total_after;
               gce_in = '0;
               phase_in = PH_IMG_SIZE;
            end
            default: begin
               // idle: bytes dropped until a final byte
               phase_in = phase_ff;
            end
         endcase

         res.frame_count = frames_in;

         // last byte of the file: close the stream, then reset per-file state
         if (req_chan.final_byte) begin
            closed = res_valid && (res.kind == KIND_END || res.kind == KIND_ERROR);
            if (!closed) begin
               if (phase_in == PH_BLOCK) begin
                  res = '0;
                  res_valid = 1'b1;
                  res.kind = KIND_END;
                  res.delay_ms = total_in;
                  res.frame_count = frames_in;
               end else if (phase_in != PH_IDLE) begin
                  res = '0;
                  res_valid = 1'b1;
                  res.kind = KIND_ERROR;
                  res.payload_byte = ERR_EARLY_END;
                  res.frame_count = frames_in;
               end
            end
            phase_in        = PH_HDR;
            count_in        = 10'd0;
            left_in         = 8'd0;
            canvas_w_in     = 16'd0;
            canvas_h_in     = 16'd0;
            screen_flags_in = 8'd0;
            background_in   = 8'd0;
            geom_in         = '{default: 16'd0};
            image_flags_in  = 8'd0;
            gce_in          = '0;
            frames_in       = 16'd0;
            total_in        = 32'd0;
            sig_ok_in       = 1'b1;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_w_ff <= MAX_WIDTH_RESET;
         max_h_ff <= MAX_HEIGHT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         if (csr_chan.reg_index == CSR_MAX_WIDTH) begin
            max_w_ff <= csr_chan.data;
         end
         if (csr_chan.reg_index == CSR_MAX_HEIGHT) begin
            max_h_ff <= csr_chan.data;
         end
      end
   end

   // parse state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR;
         count_ff        <= 10'd0;
         left_ff         <= 8'd0;
         canvas_w_ff     <= 16'd0;
         canvas_h_ff     <= 16'd0;
         screen_flags_ff <= 8'd0;
         background_ff   <= 8'd0;
         geom_ff         <= '{default: 16'd0};
         image_flags_ff  <= 8'd0;
         gce_ff          <= '0;
         frames_ff       <= 16'd0;
         total_ff        <= 32'd0;
         sig_ok_ff       <= 1'b1;
      end else begin
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         left_ff         <= left_in;
         canvas_w_ff     <= canvas_w_in;
         canvas_h_ff     <= canvas_h_in;
         screen_flags_ff <= screen_flags_in;
         background_ff   <= background_in;
         geom_ff         <= geom_in;
         image_flags_ff  <= image_flags_in;
         gce_ff          <= gce_in;
         frames_ff       <= frames_in;
         total_ff        <= total_in;
         sig_ok_ff       <= sig_ok_in;
      end
   end

   // result register: loaded on a byte transfer that gives a result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= res_valid;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.kind            = rsp_ff.kind;
   assign rsp_chan.coord_x         = rsp_ff.coord_x;
   assign rsp_chan.coord_y         = rsp_ff.coord_y;
   assign rsp_chan.extent_w        = rsp_ff.extent_w;
   assign rsp_chan.extent_h        = rsp_ff.extent_h;
   assign rsp_chan.packed_flags    = rsp_ff.packed_flags;
   assign rsp_chan.disposal        = rsp_ff.disposal;
   assign rsp_chan.has_transparent = rsp_ff.has_transparent;
   assign rsp_chan.palette_index   = rsp_ff.palette_index;
   assign rsp_chan.delay_ms        = rsp_ff.delay_ms;
   assign rsp_chan.payload_byte    = rsp_ff.payload_byte;
   assign rsp_chan.frame_count     = rsp_ff.frame_count;

`ifndef SYNTHESIS
   // a final byte always leaves the parser at the start of a fresh file
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_chan.final_byte |=>
         phase_ff == PH_HDR && count_ff == 10'd0 && frames_ff == 16'd0 &&
         total_ff == 32'd0)
      else $error("final byte did not restart the parser");

   // colour table skip never sits on an exhausted count
   a_table_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_GCT || phase_ff == PH_LCT) |-> count_ff != 10'd0)
      else $error("colour table skip with zero count");

   // after end or error only a final byte leaves the idle phase
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE && !(accept && req_chan.final_byte) |=> phase_ff == PH_IDLE)
      else $error("idle phase left without a final byte");

   // an empty result slot never holds back the byte stream
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_chan.ready)
      else $error("byte stream stalled with empty result register");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of gif_block_structure_parser_core: directed and random gif files
// with a cycle-free behavioural parser predicting every record. depends on gbsp_pkg,
// gbsp_channels and the core
`timescale 1ns / 1ps

module testbench;
   import gbsp_pkg::*;

   localparam logic [47:0] GIF_SIG = "GIF89a";
   localparam logic [31:0] MS_PER_TICK = 32'd10;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 8'd2;   // unmapped register index
   localparam int RANDOM_BYTES  = 360;
   localparam int STALL_LIMIT   = 2000;   // cycles without any transfer
   localparam int SETTLE_CYCLES = 4;      // result register latency plus margin
   localparam int LONG_FRAMES   = 8;      // frames of 655.35 s each, back to back
   localparam int PRESSURE_HOLD = 400;

   typedef enum {RX_STEADY, RX_LIGHT, RX_HEAVY, RX_PULSE} stall_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gbsp_req_if req_chan();
   gbsp_rsp_if rsp_chan();
   gbsp_csr_if csr_chan();

   gif_block_structure_parser_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // behavioural parser: own copy of limits and per-file state
   // ---------------------------------------------------------------------------------------
   phase_type   ph;
   int          pos;            // header, descriptor, table or control block byte counter
   logic [7:0]  sub_left;
   logic [15:0] canvas_w, canvas_h;
   logic [7:0]  screen_flags, bg_index, img_flags;
   logic [15:0] geom [4];       // x, y, w, h of the current descriptor
   gce_type     gce;
   logic [15:0] frames;
   logic [31:0] total_ms;
   bit          sig_good;
   logic [15:0] limit_w, limit_h;

   result_type  pending_records [$];
   logic [7:0]  gif_q [$];      // bytes of the file being built
   int          mismatches = 0;
   int          bytes_sent = 0;
   int unsigned quiet_cycles = 0;

   // sender and receiver pacing
   int                burst_left = 0;
   bit                tx_eager = 1'b0;
   bit                rx_eager = 1'b0;
   int                hold_off_left = 0;
   stall_pattern_type rx_mode = RX_STEADY;
   int                rx_mode_left = 0;
   int unsigned       rx_tick = 0;

   function automatic void restart_file();
      ph = PH_HDR;
      pos = 0;
      sub_left = '0;
      canvas_w = '0;
      canvas_h = '0;
      screen_flags = '0;
      bg_index = '0;
      for (int i = 0; i < 4; i++) geom[i] = '0;
      img_flags = '0;
      gce = '0;
      frames = '0;
      total_ms = '0;
      sig_good = 1'b1;
   endfunction

   function automatic result_type blank(input kind_type k);
      result_type r;
      r = '0;
      r.kind = k;
      r.frame_count = frames;
      return r;
   endfunction

   function automatic result_type error_record(input logic [7:0] code);
      result_type r;
      r = blank(KIND_ERROR);
      r.payload_byte = code;
      ph = PH_IDLE;
      return r;
   endfunction

   function automatic result_type end_record();
      result_type r;
      r = blank(KIND_END);
      r.delay_ms = total_ms;
      ph = PH_IDLE;
      return r;
   endfunction

   // returns 1 when the byte yields a record
   function automatic bit parse_byte(input logic [7:0] b, input bit fin, output result_type r);
      bit          hit;
      logic [15:0] ticks;
      logic [31:0] step_ms;
      hit = 1'b0;
      r = '0;
      case (ph)
         PH_HDR: begin
            if (pos < 6) begin
               if (b != GIF_SIG[8*(5-pos) +: 8] && !(pos == 4 && b == BYTE_SIG_VER_87))
                  sig_good = 1'b0;
               if (pos == 5 && !sig_good) begin
                  r = error_record(ERR_SIGNATURE);
                  hit = 1'b1;
               end else begin
                  pos++;
               end
            end else if (pos < 12) begin
               case (pos)
                  6:  canvas_w = {8'h00, b};
                  7:  canvas_w[15:8] = b;
                  8:  canvas_h = {8'h00, b};
                  9:  canvas_h[15:8] = b;
                  10: screen_flags = b;
                  default: bg_index = b;
               endcase
               pos++;
            end else if (canvas_w > limit_w || canvas_h > limit_h) begin
               r = error_record(ERR_TOO_WIDE);
               hit = 1'b1;
            end else begin
               r = blank(KIND_CANVAS);
               r.extent_w = canvas_w;
               r.extent_h = canvas_h;
               r.packed_flags = screen_flags;
               r.palette_index = bg_index;
               hit = 1'b1;
               if (screen_flags[7]) begin
                  pos = 6 << screen_flags[2:0];
                  ph = PH_GCT;
               end else begin
                  ph = PH_BLOCK;
               end
            end
         end
         PH_GCT, PH_LCT: begin
            if (pos > 0) pos--;
            if (pos == 0) ph = (ph == PH_GCT) ? PH_BLOCK : PH_LZW;
         end
         PH_BLOCK: begin
            if (b == BYTE_IMAGE_SEP) begin
               pos = 0;
               ph = PH_DESC;
            end else if (b == BYTE_EXT_INTRO) begin
               ph = PH_EXT_LABEL;
            end else if (b == BYTE_TRAILER) begin
               r = end_record();
               hit = 1'b1;
            end
         end
         PH_EXT_LABEL: begin
            if (b == BYTE_GCE_LABEL) begin
               gce = '0;
               gce.present = 1'b1;
               ph = PH_GCE_SIZE;
            end else begin
               ph = PH_EXT_SIZE;
            end
         end
         PH_GCE_SIZE: begin
            if (b == 8'h00) begin
               ph = PH_BLOCK;
            end else begin
               sub_left = b;
               pos = 0;
               ph = PH_GCE_DATA;
            end
         end
         PH_GCE_DATA: begin
            case (pos)
               0: begin
                  gce.disposal = b[4:2];
                  gce.tflag = b[0];
               end
               1: gce.delay[7:0] = b;
               2: gce.delay[15:8] = b;
               3: gce.tidx = b;
               default: ;
            endcase
            if (pos < 4) pos++;
            sub_left--;
            if (sub_left == 8'h00) ph = PH_EXT_SIZE;
         end
         PH_EXT_SIZE, PH_IMG_SIZE: begin
            if (b == 8'h00) begin
               ph = PH_BLOCK;
            end else begin
               sub_left = b;
               ph = (ph == PH_EXT_SIZE) ? PH_EXT_DATA : PH_IMG_DATA;
            end
         end
         PH_EXT_DATA, PH_IMG_DATA: begin
            if (ph == PH_IMG_DATA) begin
               r = blank(KIND_DATA);
               r.payload_byte = b;
               hit = 1'b1;
            end
            sub_left--;
            if (sub_left == 8'h00) ph = (ph == PH_EXT_DATA) ? PH_EXT_SIZE : PH_IMG_SIZE;
         end
         PH_DESC: begin
            if (pos < 8) begin
               if (pos % 2 == 1) geom[pos/2][15:8] = b;
               else geom[pos/2] = {8'h00, b};
               pos++;
            end else begin
               img_flags = b;
               if (b[7]) begin
                  pos = 6 << b[2:0];
                  ph = PH_LCT;
               end else begin
                  ph = PH_LZW;
               end
            end
         end
         PH_LZW: begin
            // frame record: count, geometry, control block fields and delay
            if (frames != 16'hFFFF) frames++;
            r = blank(KIND_FRAME);
            r.coord_x = geom[0];
            r.coord_y = geom[1];
            r.extent_w = geom[2];
            r.extent_h = geom[3];
            r.packed_flags = img_flags;
            step_ms = '0;
            if (gce.present) begin
               ticks = (gce.delay < DELAY_MIN_TICKS) ? DELAY_MIN_TICKS : gce.delay;
               step_ms = 32'(ticks) * MS_PER_TICK;
               r.disposal = gce.disposal;
               r.has_transparent = gce.tflag;
               r.palette_index = gce.tidx;
            end
            r.delay_ms = step_ms;
            r.payload_byte = b;
            total_ms = (total_ms > 32'hFFFF_FFFF - step_ms) ? 32'hFFFF_FFFF : total_ms + step_ms;
            gce = '0;
            ph = PH_IMG_SIZE;
            hit = 1'b1;
         end
         default: ;
      endcase

      // last byte of a file: close it cleanly or flag an early end, then start afresh
      if (fin) begin
         if (!(hit && (r.kind == KIND_END || r.kind == KIND_ERROR))) begin
            if (ph == PH_BLOCK) begin
               r = end_record();
               hit = 1'b1;
            end else if (ph != PH_IDLE) begin
               r = error_record(ERR_EARLY_END);
               hit = 1'b1;
            end
         end
         restart_file();
      end
      return hit;
   endfunction

   // ---------------------------------------------------------------------------------------
   // scoreboard, prediction and watchdog, all sampled at the rising edge
   // ---------------------------------------------------------------------------------------
   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want, fresh;
      if (!reset) begin
         // results first, so the front of the queue is always an older byte
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_records.size() == 0) begin
               $error("record of kind %0d with nothing expected", rsp_chan.kind);
               mismatches++;
            end else begin
               want = pending_records.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_chan.kind));
               check_field("coord_x", 32'(want.coord_x), 32'(rsp_chan.coord_x));
               check_field("coord_y", 32'(want.coord_y), 32'(rsp_chan.coord_y));
               check_field("extent_w", 32'(want.extent_w), 32'(rsp_chan.extent_w));
               check_field("extent_h", 32'(want.extent_h), 32'(rsp_chan.extent_h));
               check_field("packed_flags", 32'(want.packed_flags),
                           32'(rsp_chan.packed_flags));
               check_field("disposal", 32'(want.disposal), 32'(rsp_chan.disposal));
               check_field("has_transparent", 32'(want.has_transparent),
                           32'(rsp_chan.has_transparent));
               check_field("palette_index", 32'(want.palette_index),
                           32'(rsp_chan.palette_index));
               check_field("delay_ms", want.delay_ms, rsp_chan.delay_ms);
               check_field("payload_byte", 32'(want.payload_byte),
                           32'(rsp_chan.payload_byte));
               check_field("frame_count", 32'(want.frame_count), 32'(rsp_chan.frame_count));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            if (parse_byte(req_chan.file_byte, req_chan.final_byte, fresh))
               pending_records.push_back(fresh);
         end
         // watchdog on any transfer at all
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("TEST FAILED");
               $finish;
            end
         end
      end
   end

   // receiver: own stall patterns, plus a long hold-off on request
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_off_left--;
         end else if (rx_eager) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            if (rx_mode_left == 0) begin
               rx_mode = stall_pattern_type'($urandom_range(0, 3));
               rx_mode_left = $urandom_range(16, 128);
            end
            rx_mode_left--;
            rx_tick++;
            case (rx_mode)
               RX_STEADY: rsp_chan.ready <= 1'b1;
               RX_LIGHT:  rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY:  rsp_chan.ready <= ($urandom_range(0, 2) == 0);
               default:   rsp_chan.ready <= (rx_tick % 7 < 2);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------------------------
   // one byte transfer; gaps only open at the start of a burst
   task automatic send_byte(input logic [7:0] b, input bit fin);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!tx_eager && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.file_byte <= b;
      req_chan.final_byte <= fin;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   // sender off, every expected record in, then let a byte without a record settle
   task automatic drain();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [15:0] value);
      drain();
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.reg_index <= idx;
      csr_chan.data <= value;
      do @(posedge clock); while (!csr_chan.ready);
      if (idx == CSR_MAX_WIDTH) limit_w = value;
      else if (idx == CSR_MAX_HEIGHT) limit_h = value;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   // send the built file up to and including byte cut, which carries the final mark
   task automatic send_gif(input int cut);
      for (int i = 0; i <= cut; i++) send_byte(gif_q[i], i == cut);
      gif_q.delete();
   endtask

   // ---------------------------------------------------------------------------------------
   // file builders
   // ---------------------------------------------------------------------------------------
   function automatic void put16(input logic [15:0] v);
      gif_q.push_back(v[7:0]);
      gif_q.push_back(v[15:8]);
   endfunction

   function automatic void put_random(input int n);
      repeat (n) gif_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // n sub-blocks of random data then the terminator
   function automatic void put_subblocks(input int n, input int maxlen);
      int len;
      repeat (n) begin
         len = $urandom_range(1, maxlen);
         gif_q.push_back(8'(len));
         put_random(len);
      end
      gif_q.push_back(8'h00);
   endfunction

   function automatic void put_header(input bit sig_ok, input bit v87, input logic [15:0] w,
                                      input logic [15:0] h, input logic [7:0] flags,
                                      input logic [7:0] bg);
      logic [47:0] sig;
      logic [7:0]  bad;
      int          k;
      sig = v87 ? 48'("GIF87a") : GIF_SIG;
      if (!sig_ok) begin
         k = $urandom_range(0, 5);
         do bad = 8'($urandom_range(0, 255));
         while (bad == GIF_SIG[8*(5-k) +: 8] || (k == 4 && bad == BYTE_SIG_VER_87));
         sig[8*(5-k) +: 8] = bad;
      end
      for (int i = 5; i >= 0; i--) gif_q.push_back(sig[8*i +: 8]);
      put16(w);
      put16(h);
      gif_q.push_back(flags);
      gif_q.push_back(bg);
      if (flags[7]) put_random(6 << flags[2:0]);
   endfunction

   // control block with a first sub-block of the given size
   function automatic void put_gce(input int size, input logic [7:0] flags,
                                   input logic [15:0] delay, input logic [7:0] tidx,
                                   input int extra);
      logic [31:0] body;
      body = {tidx, delay, flags};
      gif_q.push_back(BYTE_EXT_INTRO);
      gif_q.push_back(BYTE_GCE_LABEL);
      gif_q.push_back(8'(size));
      for (int i = 0; i < size; i++)
         gif_q.push_back(i < 4 ? body[8*i +: 8] : 8'($urandom_range(0, 255)));
      if (size != 0) put_subblocks(extra, 4);
   endfunction

   function automatic void put_extension(input logic [7:0] label);
      gif_q.push_back(BYTE_EXT_INTRO);
      gif_q.push_back(label);
      put_subblocks($urandom_range(0, 2), 6);
   endfunction

   // separator, descriptor, optional local table and code size; data is up to the caller
   function automatic void put_image(input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] w, input logic [15:0] h,
                                     input logic [7:0] flags, input logic [7:0] lzw);
      gif_q.push_back(BYTE_IMAGE_SEP);
      put16(x);
      put16(y);
      put16(w);
      put16(h);
      gif_q.push_back(flags);
      if (flags[7]) put_random(6 << flags[2:0]);
      gif_q.push_back(lzw);
   endfunction

   function automatic logic [15:0] pick_extent(input logic [15:0] lim);
      case ($urandom_range(0, 7))
         0: return lim;
         1: return (lim == 16'hFFFF) ? lim : 16'($urandom_range(int'(lim) + 1, 65535));
         2: return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, int'(lim)));
      endcase
   endfunction

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 16'd1;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 65535));
         default: return 16'($urandom_range(1, 1000));
      endcase
   endfunction

   function automatic logic [15:0] pick_delay();
      case ($urandom_range(0, 4))
         0: return 16'd0;
         1: return 16'd1;
         2: return 16'd2;
         3: return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // mostly a well-formed file with random content, sometimes cut short or broken
   task automatic random_file();
      logic [7:0] flags, stray, label;
      int         style;
      flags = 8'($urandom_range(0, 255));
      if (flags[7]) flags[2:0] = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(0, 7))
                                                             : 3'($urandom_range(0, 2));
      put_header($urandom_range(0, 19) != 0, 1'($urandom_range(0, 1)), pick_extent(limit_w),
                 pick_extent(limit_h), flags, 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 5)) begin
         case ($urandom_range(0, 9))
            0, 1, 2: put_gce(($urandom_range(0, 3) != 0) ? 4 : $urandom_range(0, 6),
                             8'($urandom_range(0, 255)), pick_delay(),
                             8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0) ? 1 : 0);
            3: begin
               do label = 8'($urandom_range(0, 255)); while (label == BYTE_GCE_LABEL);
               put_extension(label);
            end
            4: begin
               // unknown introducer between blocks
               do stray = 8'($urandom_range(0, 255));
               while (stray == BYTE_IMAGE_SEP || stray == BYTE_EXT_INTRO ||
                      stray == BYTE_TRAILER);
               gif_q.push_back(stray);
            end
            default: begin
               flags = 8'($urandom_range(0, 255));
               if (flags[7]) flags[2:0] = 3'($urandom_range(0, 1));
               put_image(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                         flags, 8'($urandom_range(0, 255)));
               put_subblocks($urandom_range(0, 3), ($urandom_range(0, 7) == 0) ? 40 : 8);
            end
         endcase
      end
      style = $urandom_range(0, 9);
      if (style < 6) begin
         gif_q.push_back(BYTE_TRAILER);
         send_gif(gif_q.size() - 1);
      end else if (style == 6) begin
         send_gif(gif_q.size() - 1);                 // no trailer, last byte closes
      end else if (style == 7) begin
         gif_q.push_back(BYTE_TRAILER);
         put_random($urandom_range(1, 4));           // junk after the trailer
         send_gif(gif_q.size() - 1);
      end else begin
         send_gif($urandom_range(0, gif_q.size() - 1));
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------------------
   // one file touching every block kind and the control block corners
   task automatic test_reference_file();
      put_header(1'b1, 1'b0, MAX_WIDTH_RESET, MAX_HEIGHT_RESET, 8'h80, 8'hFF);
      put_gce(4, 8'h1D, 16'h0000, 8'hFF, 0);       // disposal 7, transparent, zero delay
      put_extension(8'hFE);
      gif_q.push_back(8'h00);                      // unknown introducer, skipped
      put_image(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 8'h81, 8'h08);
      gif_q.push_back(8'h02);
      gif_q.push_back(8'h00);
      gif_q.push_back(8'hFF);
      gif_q.push_back(8'h00);
      put_gce(2, 8'h00, 16'h0001, 8'h00, 0);       // short sub-block, delay below minimum
      put_image(16'd1, 16'd2, 16'd3, 16'd4, 8'h40, 8'h02);
      put_subblocks(1, 3);
      put_gce(0, 8'h00, 16'h0000, 8'h00, 0);       // empty control block still counts
      put_image(16'd5, 16'd6, 16'd7, 16'd8, 8'h00, 8'h03);
      put_subblocks(1, 2);
      put_gce(6, 8'h0E, 16'hFFFF, 8'h5A, 1);       // long block plus a trailing sub-block
      put_image(16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 8'h20, 8'hFF);
      put_subblocks(2, 4);
      put_image(16'd0, 16'd0, 16'd1, 16'd1, 8'h00, 8'h00);  // no control block
      put_subblocks(0, 1);
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
   endtask

   task automatic test_bad_signature();
      // "GIF88a": error on the sixth byte, rest dropped until the final byte
      gif_q = '{8'h47, 8'h49, 8'h46, 8'h38, 8'h38, 8'h61, BYTE_IMAGE_SEP, BYTE_TRAILER};
      send_gif(gif_q.size() - 1);
      // first character wrong, final on the sixth byte itself
      gif_q = '{8'h00, 8'h49, 8'h46, 8'h38, 8'h39, 8'h61};
      send_gif(gif_q.size() - 1);
      // version 87a is accepted; trailer not marked final, junk after it
      put_header(1'b1, 1'b1, 16'd2, 16'd2, 8'h00, 8'h00);
      gif_q.push_back(BYTE_TRAILER);
      put_random(2);
      send_gif(gif_q.size() - 1);
   endtask

   task automatic test_canvas_limits();
      write_csr(CSR_MAX_WIDTH, 16'd1);
      write_csr(CSR_MAX_HEIGHT, 16'd1);
      put_header(1'b1, 1'b0, 16'd1, 16'd1, 8'h00, 8'h00);
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
      put_header(1'b1, 1'b0, 16'd2, 16'd1, 8'h00, 8'h00);   // too wide
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
      put_header(1'b1, 1'b0, 16'd0, 16'd2, 8'h00, 8'h00);   // too tall
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
      write_csr(CSR_MAX_WIDTH, 16'hFFFF);
      write_csr(CSR_MAX_HEIGHT, 16'hFFFF);
      write_csr(CSR_SPARE, 16'h0001);                        // unmapped, no effect
      put_header(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 8'h87, 8'h00);  // largest colour table
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
      write_csr(CSR_MAX_WIDTH, MAX_WIDTH_RESET);
      write_csr(CSR_MAX_HEIGHT, MAX_HEIGHT_RESET);
   endtask

   task automatic test_last_byte();
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h00, 8'h00);
      send_gif(12);                                // canvas byte is last: end replaces it
      put_header(1'b1, 1'b1, 16'd4, 16'd4, 8'h00, 8'h00);
      send_gif(8);                                 // inside the header
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h00, 8'h00);
      put_image(16'd0, 16'd0, 16'd4, 16'd4, 8'h00, 8'h02);
      gif_q.push_back(8'h03);
      put_random(3);
      gif_q.push_back(8'h00);
      send_gif(gif_q.size() - 3);                  // on a data byte: early end replaces it
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h00, 8'h00);
      put_image(16'd0, 16'd0, 16'd4, 16'd4, 8'h00, 8'h02);
      put_subblocks(1, 4);
      send_gif(gif_q.size() - 1);                  // on the terminator: clean end
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h82, 8'h00);
      send_gif(20);                                // inside the global colour table
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h00, 8'h00);
      gif_q.push_back(BYTE_EXT_INTRO);
      gif_q.push_back(8'hFE);
      send_gif(gif_q.size() - 1);                  // on an extension label
      put_header(1'b1, 1'b0, 16'd4, 16'd4, 8'h00, 8'h00);
      put_gce(4, 8'h05, 16'd3, 8'h11, 0);
      send_gif(gif_q.size() - 2);                  // inside the control block
   endtask

   // longest delays on every frame, sent and taken at full rate
   task automatic test_long_delays();
      drain();
      tx_eager = 1'b1;
      rx_eager = 1'b1;
      put_header(1'b1, 1'b0, 16'd1, 16'd1, 8'h00, 8'h00);
      repeat (LONG_FRAMES) begin
         put_gce(4, 8'($urandom_range(0, 255)), 16'hFFFF, 8'($urandom_range(0, 255)), 0);
         put_image(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   8'h00, 8'h02);
         put_subblocks(1, 1);
      end
      gif_q.push_back(BYTE_TRAILER);
      send_gif(gif_q.size() - 1);
      drain();
      tx_eager = 1'b0;
      rx_eager = 1'b0;
   endtask

   // receiver holds off while a data-heavy image keeps coming: the input must stall
   task automatic test_back_pressure();
      drain();
      tx_eager = 1'b1;
      put_header(1'b1, 1'b0, 16'd1, 16'd1, 8'h00, 8'h00);
      put_image(16'd0, 16'd0, 16'd1, 16'd1, 8'h00, 8'h02);
      put_subblocks(4, 60);
      gif_q.push_back(BYTE_TRAILER);
      hold_off_left = PRESSURE_HOLD;
      send_gif(gif_q.size() - 1);
      tx_eager = 1'b0;
   endtask

   task automatic test_random_files();
      int start, files;
      start = bytes_sent;
      files = 0;
      while (bytes_sent - start < RANDOM_BYTES) begin
         if (files % 6 == 0) begin
            write_csr(CSR_MAX_WIDTH, pick_limit());
            write_csr(CSR_MAX_HEIGHT, pick_limit());
            tx_eager = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 9) == 0) begin
            put_random($urandom_range(1, 20));     // plain noise with a final mark
            send_gif(gif_q.size() - 1);
         end else begin
            random_file();
         end
         files++;
      end
      tx_eager = 1'b0;
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.file_byte = 8'h00;
      req_chan.final_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.reg_index = CSR_MAX_WIDTH;
      csr_chan.data = 16'h0000;
      limit_w = MAX_WIDTH_RESET;
      limit_h = MAX_HEIGHT_RESET;
      restart_file();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reference_file();
      test_bad_signature();
      test_canvas_limits();
      test_last_byte();
      test_back_pressure();
      test_long_delays();
      test_random_files();
      drain();

      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/gbsp_pkg.sv
rtl/gbsp_channels.sv
rtl/gbsp_delay_calc.sv
rtl/gif_block_structure_parser_core.sv
tb/testbench.sv
